>>> src/rectangle_raster_fill_outline_top_macros.svh
// Assertion macros used by the rasterizer top level.
`ifndef RECTANGLE_RASTER_FILL_OUTLINE_TOP_MACROS_SVH
`define RECTANGLE_RASTER_FILL_OUTLINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rfo_pkg.sv
// Package with codes, defaults and types of the rectangle rasterizer.
`timescale 1ns / 1ps
package rfo_pkg;

  localparam int MaxDimDefault   = 256;
  localparam int FracBitsDefault = 8;

  localparam int CoordW   = 24;
  localparam int CfgDataW = 9;
  localparam int CfgIdxW  = 2;

  localparam logic [1:0] KindClear = 2'd0;
  localparam logic [1:0] KindDraw  = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBad     = 2'd1;
  localparam logic [1:0] StatusRefused = 2'd2;

  localparam logic [7:0] ShapeFilled  = 8'h52;
  localparam logic [7:0] ShapeOutline = 8'h72;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBack   = 2'd2;

  localparam logic [8:0] WidthReset  = 9'd1;
  localparam logic [8:0] HeightReset = 9'd1;
  localparam logic [7:0] BackReset   = 8'd32;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSweep = 3'b010,
    StDone  = 3'b100
  } state_e;

endpackage

>>> src/rectangle_raster_fill_outline_top.sv
// Rectangle rasterizer: a clear or a draw item sweeps the canvas in use one pixel per cycle
// through the single port of the canvas RAM; a read item, a refused or bad draw and an unused
// kind skip the sweep. The next word is taken once the current one has reached the output
// register. The canvas holds garbage after reset until the first clear; there is no
// clearing pass.
`timescale 1ns / 1ps
module rectangle_raster_fill_outline_top #(
  parameter int MaxDim   = rfo_pkg::MaxDimDefault,
  parameter int FracBits = rfo_pkg::FracBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfo_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    shape_code_i,
  input  logic signed [rfo_pkg::CoordW-1:0] left_edge_i,
  input  logic signed [rfo_pkg::CoordW-1:0] top_edge_i,
  input  logic signed [rfo_pkg::CoordW-1:0] span_x_i,
  input  logic signed [rfo_pkg::CoordW-1:0] span_y_i,
  input  logic [7:0]                    paint_code_i,
  input  logic [7:0]                    read_column_i,
  input  logic [7:0]                    read_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    pixel_code_o
);

  import rfo_pkg::*;

  `include "rectangle_raster_fill_outline_top_macros.svh"

  localparam int DimW    = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int DimCntW = DimW + 1;
  localparam int AddrW   = 2 * DimW;
  localparam int Depth   = 1 << AddrW;
  // Bounds: a 24-bit corner plus a 24-bit span, with room for rounding up.
  localparam int BndW    = CoordW + 2;
  localparam logic signed [BndW-1:0] OneM1 = BndW'((1 << FracBits) - 1);

  logic [8:0] cfg_width_q, cfg_height_q;
  logic [7:0] cfg_back_q;
  logic [DimCntW-1:0] w_eff, h_eff;

  state_e state_q, state_d;
  logic error_seen_q;
  logic [1:0] res_status_q;
  logic rd_hit_q;
  logic clear_q, outline_q;
  logic [7:0] paint_q;
  logic signed [BndW-1:0] bx0_q, bx1_q, by0_q, by1_q;
  logic [DimW-1:0] col_q, row_q;
  logic out_valid_q;
  logic [1:0] out_status_q;
  logic [7:0] out_pixel_q;

  logic in_accept, out_load;
  logic draw_bad, rd_in_range;
  logic signed [BndW-1:0] x0_ext, y0_ext, x_end, y_end, x_ceil, y_ceil;
  logic signed [BndW-1:0] cx, cy;
  logic in_x, in_y, on_edge, paint_px;
  logic col_last, row_last;
  logic ram_en, ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;

  // Register values outside the legal range act as the nearest legal size.
  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = DimCntW'(1);
    end else if (32'(cfg_width_q) > MaxDim) begin
      w_eff = DimCntW'(MaxDim);
    end else begin
      w_eff = DimCntW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = DimCntW'(1);
    end else if (32'(cfg_height_q) > MaxDim) begin
      h_eff = DimCntW'(MaxDim);
    end else begin
      h_eff = DimCntW'(cfg_height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_back_q   <= BackReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  cfg_width_q  <= cfg_data_i;
        CfgHeight: cfg_height_q <= cfg_data_i;
        CfgBack:   cfg_back_q   <= cfg_data_i[7:0];
        default:   ;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign draw_bad = ((shape_code_i != ShapeFilled) && (shape_code_i != ShapeOutline))
                    || span_x_i[CoordW-1] || (span_x_i == '0)
                    || span_y_i[CoordW-1] || (span_y_i == '0);
  assign rd_in_range = (32'(read_column_i) < 32'(w_eff)) && (32'(read_row_i) < 32'(h_eff));

  // Integer pixel bounds: the first pixel at or right of the left edge and the last pixel at
  // or left of the right edge. An outline pixel is then one that sits on a bound.
  assign x0_ext = BndW'(left_edge_i);
  assign y0_ext = BndW'(top_edge_i);
  assign x_end  = x0_ext + BndW'(span_x_i);
  assign y_end  = y0_ext + BndW'(span_y_i);
  assign x_ceil = x0_ext + OneM1;
  assign y_ceil = y0_ext + OneM1;

  assign cx = $signed(BndW'(col_q));
  assign cy = $signed(BndW'(row_q));
  assign in_x = (cx >= bx0_q) && (cx <= bx1_q);
  assign in_y = (cy >= by0_q) && (cy <= by1_q);
  assign on_edge = (cx == bx0_q) || (cx == bx1_q) || (cy == by0_q) || (cy == by1_q);
  assign paint_px = clear_q || (in_x && in_y && (!outline_q || on_edge));

  assign col_last = (DimCntW'(col_q) + DimCntW'(1)) == w_eff;
  assign row_last = (DimCntW'(row_q) + DimCntW'(1)) == h_eff;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if ((kind_i == KindClear) || ((kind_i == KindDraw) && !error_seen_q && !draw_bad)) begin
            state_d = StSweep;
          end else begin
            state_d = StDone;
          end
        end
      end
      StSweep: begin
        if (col_last && row_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      error_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_status_q <= StatusOk;
      rd_hit_q     <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        col_q    <= '0;
        row_q    <= '0;
        rd_hit_q <= (kind_i == KindRead) && rd_in_range;
        case (kind_i)
          KindClear: begin
            error_seen_q <= 1'b0;
            res_status_q <= StatusOk;
          end
          KindDraw: begin
            if (error_seen_q) begin
              res_status_q <= StatusRefused;
            end else if (draw_bad) begin
              error_seen_q <= 1'b1;
              res_status_q <= StatusBad;
            end else begin
              res_status_q <= StatusOk;
            end
          end
          KindRead: res_status_q <= error_seen_q ? StatusRefused : StatusOk;
          default:  res_status_q <= StatusOk;
        endcase
      end else if (state_q == StSweep) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + DimW'(1);
        end else begin
          col_q <= col_q + DimW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload held for the sweep and the result word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      clear_q   <= (kind_i == KindClear);
      outline_q <= (shape_code_i == ShapeOutline);
      paint_q   <= paint_code_i;
      bx0_q     <= x_ceil >>> FracBits;
      bx1_q     <= x_end >>> FracBits;
      by0_q     <= y_ceil >>> FracBits;
      by1_q     <= y_end >>> FracBits;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pixel_q  <= rd_hit_q ? ram_rdata : '0;
    end
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {row_q, col_q};
    ram_wdata = clear_q ? cfg_back_q : paint_q;
    if (state_q == StSweep) begin
      ram_en = paint_px;
      ram_we = paint_px;
    end else if (in_accept && (kind_i == KindRead)) begin
      ram_en   = 1'b1;
      ram_addr = {DimW'(read_row_i), DimW'(read_column_i)};
    end
  end

  rfo_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_canvas (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pixel_code_o = out_pixel_q;

  `RFO_ASSERT_NOW(a_write_in_sweep, ram_we, state_q == StSweep, "canvas written outside a sweep")
  `RFO_ASSERT_NOW(a_sweep_in_canvas, state_q == StSweep,
    (DimCntW'(col_q) < w_eff) && (DimCntW'(row_q) < h_eff), "sweep left the canvas in use")
  `RFO_ASSERT_NEXT(a_refused_draw, in_accept && (kind_i == KindDraw) && error_seen_q,
    (state_q == StDone) && (res_status_q == StatusRefused) && error_seen_q,
    "draw after an error was not refused")
  `RFO_ASSERT_NEXT(a_clear_flag, in_accept && (kind_i == KindClear),
    !error_seen_q && (state_q == StSweep), "clear did not reset the error flag")
  `RFO_ASSERT_NEXT(a_result_load, out_load, out_valid_q && (state_q == StIdle),
    "finished item did not reach the output register")

endmodule

>>> src/rfo_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module rfo_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the rectangle fill and outline rasterizer top level.
`timescale 1ns / 1ps
module testbench;
  import rfo_pkg::*;

  localparam int MaxDim = MaxDimDefault;
  localparam int PixelStep = 1 << FracBitsDefault;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int RxHoldCycles = 2000;
  localparam int DrainCycles = 50;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        shape;
    logic signed [23:0] left_edge;
    logic signed [23:0] top_edge;
    logic signed [23:0] span_x;
    logic signed [23:0] span_y;
    logic [7:0]        paint;
    logic [7:0]        read_column;
    logic [7:0]        read_row;
  } rect_item_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] pixel_code;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] pixel_code;
  rect_item_t drv_item = '{default: '0};

  // Software image of the block: canvas, sticky error flag and registers.
  logic [7:0] model_canvas [MaxDim*MaxDim];
  logic model_error = 1'b0;
  logic [8:0] model_width = WidthReset;
  logic [8:0] model_height = HeightReset;
  logic [7:0] model_back = BackReset;

  rect_item_t pending_items[$];
  answer_t predicted_answers[$];
  answer_t want;
  int n_issued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  bit in_fire = 1'b0;
  int tx_idle_pct = 18;
  int rx_idle_pct = 86;
  int rx_hold_req = 0;
  int rx_hold_ack = 0;
  int rx_hold_left = 0;

  rectangle_raster_fill_outline_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (drv_item.kind),
    .shape_code_i  (drv_item.shape),
    .left_edge_i   (drv_item.left_edge),
    .top_edge_i    (drv_item.top_edge),
    .span_x_i      (drv_item.span_x),
    .span_y_i      (drv_item.span_y),
    .paint_code_i  (drv_item.paint),
    .read_column_i (drv_item.read_column),
    .read_row_i    (drv_item.read_row),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .pixel_code_o  (pixel_code)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_dim(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  // Applies one item to the canvas image and returns the answer it produces.
  function automatic answer_t rasterize_item(input rect_item_t it);
    answer_t ans;
    int cols, rows, r, c;
    longint x0, y0, x1, y1, sx, sy, px, py;
    bit outline, hit;
    cols = clamp_dim(model_width);
    rows = clamp_dim(model_height);
    ans.status = StatusOk;
    ans.pixel_code = 8'h00;
    case (it.kind)
      KindClear: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++)
            model_canvas[r*MaxDim + c] = model_back;
        model_error = 1'b0;
      end
      KindDraw: begin
        x0 = longint'(it.left_edge);
        y0 = longint'(it.top_edge);
        sx = longint'(it.span_x);
        sy = longint'(it.span_y);
        if (model_error) begin
          ans.status = StatusRefused;
        end else if ((it.shape != ShapeFilled && it.shape != ShapeOutline) ||
                     sx <= 0 || sy <= 0) begin
          model_error = 1'b1;
          ans.status = StatusBad;
        end else begin
          x1 = x0 + sx;
          y1 = y0 + sy;
          outline = (it.shape == ShapeOutline);
          for (r = 0; r < rows; r++) begin
            py = longint'(r) * PixelStep;
            for (c = 0; c < cols; c++) begin
              px = longint'(c) * PixelStep;
              hit = px >= x0 && px <= x1 && py >= y0 && py <= y1;
              // An outline keeps only pixels closer than one step to some edge.
              if (hit && outline)
                hit = (px - x0) < PixelStep || (x1 - px) < PixelStep ||
                      (py - y0) < PixelStep || (y1 - py) < PixelStep;
              if (hit) model_canvas[r*MaxDim + c] = it.paint;
            end
          end
        end
      end
      KindRead: begin
        if (int'(it.read_column) < cols && int'(it.read_row) < rows)
          ans.pixel_code = model_canvas[it.read_row*MaxDim + it.read_column];
        ans.status = model_error ? StatusRefused : StatusOk;
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic rect_item_t build_item(input logic [1:0] kind, input logic [7:0] shape,
                                            input logic signed [23:0] x0, y0, sx, sy,
                                            input logic [7:0] paint, col, row);
    rect_item_t it;
    it.kind = kind;
    it.shape = shape;
    it.left_edge = x0;
    it.top_edge = y0;
    it.span_x = sx;
    it.span_y = sy;
    it.paint = paint;
    it.read_column = col;
    it.read_row = row;
    return it;
  endfunction

  // Mostly well-formed draws and in-canvas reads, with some broken and raw noise items.
  function automatic rect_item_t random_item();
    rect_item_t it;
    int cols, rows, pick;
    cols = clamp_dim(model_width);
    rows = clamp_dim(model_height);
    it.kind = 2'($urandom);
    it.shape = 8'($urandom);
    it.left_edge = 24'($urandom);
    it.top_edge = 24'($urandom);
    it.span_x = 24'($urandom);
    it.span_y = 24'($urandom);
    it.paint = 8'($urandom);
    it.read_column = 8'($urandom);
    it.read_row = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.kind = KindClear;
    end else if (pick < 16) begin
      it.kind = KindUnused;
    end else if (pick < 44) begin
      it.kind = KindRead;
      if ($urandom_range(0, 4) != 0) begin
        it.read_column = 8'($urandom_range(0, cols - 1));
        it.read_row = 8'($urandom_range(0, rows - 1));
      end
    end else begin
      it.kind = KindDraw;
      if (pick < 92) begin
        it.shape = $urandom_range(0, 1) ? ShapeOutline : ShapeFilled;
        it.left_edge = 24'(int'($urandom_range(0, (cols + 8) * PixelStep)) - 4 * PixelStep);
        it.top_edge = 24'(int'($urandom_range(0, (rows + 8) * PixelStep)) - 4 * PixelStep);
        it.span_x = 24'($urandom_range(1, (cols + 4) * PixelStep));
        it.span_y = 24'($urandom_range(1, (rows + 4) * PixelStep));
      end else if (pick < 96) begin
        it.shape = $urandom_range(0, 1) ? ShapeOutline : ShapeFilled;
        if ($urandom_range(0, 1))
          it.span_x = 24'(0 - $urandom_range(0, 24'h800000));
        else
          it.span_y = 24'(0 - $urandom_range(0, 24'h800000));
      end
    end
    return it;
  endfunction

  task automatic queue_item(input rect_item_t it);
    pending_items.push_back(it);
    n_issued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgWidth:  model_width = data;
      CfgHeight: model_height = data;
      CfgBack:   model_back = data[7:0];
      default: ;
    endcase
  endtask

  // Every item yields one answer, so the block is idle once all answers are in.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || n_accepted != n_issued ||
           predicted_answers.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drv_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_ack != rx_hold_req) begin
      out_ready <= 1'b0;
      rx_hold_ack <= rx_hold_req;
      rx_hold_left <= RxHoldCycles;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid && in_ready;
    if (in_fire) begin
      predicted_answers.push_back(rasterize_item(drv_item));
      n_accepted++;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (predicted_answers.size() == 0) begin
        $display("%0t: unexpected word: status %0d, pixel %02h", $time, status, pixel_code);
        n_errors++;
      end else begin
        want = predicted_answers.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
          n_errors++;
        end
        if (pixel_code !== want.pixel_code) begin
          $display("%0t: pixel mismatch: expected %02h, got %02h",
                   $time, want.pixel_code, pixel_code);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register values after reset: a one-pixel canvas with a space background.
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd3, 8'd0));
    queue_item(build_item(KindUnused, 8'hFF, -1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF));
    queue_item(build_item(KindClear, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
    // Extreme corner and size: the far edge lands just left of the canvas.
    queue_item(build_item(KindDraw, ShapeFilled, 24'h800000, 24'h800000,
                          24'h7FFFFF, 24'h7FFFFF, 8'h41, 0, 0));
    queue_item(build_item(KindDraw, ShapeOutline, 0, 0, 24'h100, 24'h100, 8'h42, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
    queue_item(build_item(KindDraw, 8'h78, 0, 0, 24'h100, 24'h100, 8'h43, 0, 0));
    queue_item(build_item(KindDraw, ShapeFilled, 0, 0, 24'h100, 24'h100, 8'h44, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
    queue_item(build_item(KindClear, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Full canvas clear so that every later read hits a written pixel.
    write_reg(CfgWidth, 9'd511);
    write_reg(CfgHeight, 9'd256);
    write_reg(CfgBack, 9'h02E);
    queue_item(build_item(KindClear, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd255, 8'd255));
    wait_drained();

    // A zero width acts as one column: a tall single-column canvas.
    write_reg(CfgWidth, 9'd0);
    write_reg(CfgHeight, 9'd511);
    write_reg(CfgBack, 9'h0FF);
    queue_item(build_item(KindDraw, ShapeFilled, 0, 24'h1000, 24'h100, 24'h7FFFFF,
                          8'h5A, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd200));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd15));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd1, 8'd0));
    queue_item(build_item(KindDraw, ShapeOutline, 24'h7FFFFF, 0, 24'h800000, 24'h100,
                          8'h5B, 0, 0));
    queue_item(build_item(KindClear, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_item(build_item(KindDraw, ShapeOutline, -128, 24'h380, 24'h200, 24'h1F0,
                          8'h2A, 0, 0));
    queue_item(build_item(KindRead, 0, 0, 0, 0, 0, 0, 8'd0, 8'd4));
    wait_drained();

    write_reg(CfgWidth, 9'($urandom_range(2, 20)));
    write_reg(CfgHeight, 9'($urandom_range(2, 20)));
    write_reg(CfgBack, 9'h000);
    for (n = 0; n < 26; n++) begin
      // Halfway through, the sender holds back until every answer is in.
      if (n == 13) wait_drained();
      queue_item(random_item());
    end
    wait_drained();

    tx_idle_pct = 86;
    rx_idle_pct = 18;
    write_reg(CfgWidth, 9'd256);
    write_reg(CfgHeight, 9'd1);
    write_reg(CfgBack, 9'($urandom_range(0, 255)));
    for (n = 0; n < 26; n++) queue_item(random_item());
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CfgWidth, 9'($urandom_range(1, 24)));
    write_reg(CfgHeight, 9'($urandom_range(1, 24)));
    write_reg(CfgBack, 9'($urandom_range(0, 255)));
    @(posedge clk_i);
    rx_hold_req++;
    for (n = 0; n < 26; n++) queue_item(random_item());
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && predicted_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
